>>> rtl/core/hcbp_pkg.sv
// Shared constants, codes and types of the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

   // Table geometry and code limits
   localparam int MAX_CODE_LEN = 16;
   localparam int SYMBOL_COUNT = 256;
   localparam int ADDR_W       = $clog2(SYMBOL_COUNT);

   // Fixed field widths
   localparam int SYM_W   = 8;
   localparam int CODE_W  = 16;
   localparam int LEN_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int FILL_W  = 3;
   localparam int COUNT_W = 32;
   localparam int KIND_W  = 2;
   localparam int WIN_W   = CODE_W + BYTE_W;

   // Stored code length limit: the smaller of the configured maximum and the code field
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   // Request kinds
   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_LOAD   = 2'd0;
   localparam kind_type KIND_ENCODE = 2'd1;
   localparam kind_type KIND_FLUSH  = 2'd2;

   // One code table entry
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } entry_type;

   // Item issued into the pipeline on acceptance
   typedef struct packed {
      logic     vld;
      kind_type kind;
      logic     in_table;
   } issue_type;

endpackage

>>> rtl/core/hcbp_table.sv
// Code table memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module hcbp_table (
   input  logic                          clock,
   input  logic                          reset,
   input  hcbp_pkg::issue_type           issue,
   input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]   code_bits,
   input  logic [hcbp_pkg::LEN_W-1:0]    code_len,
   output hcbp_pkg::entry_type           rd_entry
);

   localparam logic [hcbp_pkg::LEN_W-1:0] LenCap = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP);

   hcbp_pkg::entry_type                   mem [hcbp_pkg::SYMBOL_COUNT];
   logic [hcbp_pkg::SYMBOL_COUNT-1:0]     valid_ff;
   logic [hcbp_pkg::SYMBOL_COUNT-1:0]     valid_in;
   hcbp_pkg::entry_type                   rd_mem_ff;
   logic                                  rd_valid_ff;
   hcbp_pkg::entry_type                   wr_entry;
   logic [hcbp_pkg::LEN_W-1:0]            wr_len;
   logic [hcbp_pkg::CODE_W:0]             wr_mask;
   logic [hcbp_pkg::ADDR_W-1:0]           addr;
   logic                                  wr_en;

   assign addr  = symbol[hcbp_pkg::ADDR_W-1:0];
   assign wr_en = issue.vld && (issue.kind == hcbp_pkg::KIND_LOAD) && issue.in_table;

   // Limit the length and clear code bits above it
   always_comb begin
      wr_len        = (code_len > LenCap) ? LenCap : code_len;
      wr_mask       = ~({(hcbp_pkg::CODE_W+1){1'b1}} << wr_len);
      wr_entry.code = code_bits & wr_mask[hcbp_pkg::CODE_W-1:0];
      wr_entry.len  = wr_len;
   end

   // Mark written entries valid
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Write a loaded entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_entry;
      end
   end

   // Read on every accepted item: register the word and its valid bit
   always_ff @(posedge clock) begin
      if (issue.vld) begin
         rd_mem_ff   <= mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   // An unwritten entry reads as zero length
   assign rd_entry = rd_valid_ff ? rd_mem_ff : '0;

endmodule

>>> rtl/core/hcbp_packer.sv
// Bit packing stage, running bit count and two-byte result register.
`timescale 1ns / 1ps

module hcbp_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hcbp_pkg::issue_type                  issue,
   input  hcbp_pkg::entry_type                  rd_entry,
   output logic                                 ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hcbp_pkg::BYTE_W-1:0]          rsp_byte,
   output logic                                 rsp_last,
   output logic [hcbp_pkg::COUNT_W-1:0]         rsp_total
);

   localparam logic [hcbp_pkg::LEN_W-1:0] CodeShift = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W);

   // Stage one control
   logic                               s1_vld_ff;
   hcbp_pkg::kind_type                 s1_kind_ff;
   logic                               s1_tab_ff;
   logic                               s1_adv;

   // Packing state
   logic [hcbp_pkg::BYTE_W-1:0]        partial_byte_ff, partial_byte_in;
   logic [hcbp_pkg::FILL_W-1:0]        bits_filled_ff, bits_filled_in;
   logic [hcbp_pkg::COUNT_W-1:0]       count_ff, count_in;

   // Result group register
   logic                               grp_vld_ff;
   logic                               grp_two_ff;
   logic [hcbp_pkg::BYTE_W-1:0]        grp_b0_ff, grp_b1_ff;
   logic [hcbp_pkg::COUNT_W-1:0]       grp_total_ff;
   logic                               grp_free;

   // Combinational packing results
   logic [hcbp_pkg::CODE_W-1:0]        enc_code;
   logic [hcbp_pkg::LEN_W-1:0]         enc_len;
   logic [hcbp_pkg::CODE_W-1:0]        code_al;
   logic [hcbp_pkg::WIN_W-1:0]         win;
   logic [hcbp_pkg::LEN_W-1:0]         total;
   logic [hcbp_pkg::COUNT_W:0]         sum;
   logic [1:0]                         n_out;
   logic [hcbp_pkg::BYTE_W-1:0]        byte0, byte1;

   // Merge the code into the pending byte
   always_comb begin
      enc_code = s1_tab_ff ? rd_entry.code : '0;
      enc_len  = s1_tab_ff ? rd_entry.len  : '0;
      code_al  = enc_code << (CodeShift - enc_len);
      win      = {partial_byte_ff, {hcbp_pkg::CODE_W{1'b0}}}
               | ({code_al, {hcbp_pkg::BYTE_W{1'b0}}} >> bits_filled_ff);
      total    = {{(hcbp_pkg::LEN_W-hcbp_pkg::FILL_W){1'b0}}, bits_filled_ff} + enc_len;
      sum      = {1'b0, count_ff} + {{(hcbp_pkg::COUNT_W+1-hcbp_pkg::LEN_W){1'b0}}, enc_len};
   end

   // Work out results and next state per item kind
   always_comb begin
      n_out           = 2'd0;
      byte0           = win[hcbp_pkg::WIN_W-1 -: hcbp_pkg::BYTE_W];
      byte1           = win[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W];
      partial_byte_in = partial_byte_ff;
      bits_filled_in  = bits_filled_ff;
      count_in        = count_ff;
      case (s1_kind_ff)
         hcbp_pkg::KIND_ENCODE: begin
            n_out          = total[hcbp_pkg::LEN_W-1:hcbp_pkg::FILL_W];
            bits_filled_in = total[hcbp_pkg::FILL_W-1:0];
            case (n_out)
               2'd0:    partial_byte_in = win[hcbp_pkg::WIN_W-1 -: hcbp_pkg::BYTE_W];
               2'd1:    partial_byte_in = win[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W];
               default: partial_byte_in = win[hcbp_pkg::BYTE_W-1:0];
            endcase
            count_in = sum[hcbp_pkg::COUNT_W] ? '1 : sum[hcbp_pkg::COUNT_W-1:0];
         end
         hcbp_pkg::KIND_FLUSH: begin
            byte0 = partial_byte_ff;
            if (bits_filled_ff != '0) begin
               n_out           = 2'd1;
               partial_byte_in = '0;
               bits_filled_in  = '0;
            end
         end
         default: begin
            n_out = 2'd0;
         end
      endcase
   end

   // Advance when the item yields no bytes or the result register can take them
   assign grp_free = !grp_vld_ff || (rsp_ready && !grp_two_ff);
   assign s1_adv   = s1_vld_ff && ((n_out == 2'd0) || grp_free);
   assign ready    = !s1_vld_ff || s1_adv;

   // Stage one registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (ready) begin
         s1_vld_ff <= issue.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         s1_kind_ff <= issue.kind;
         s1_tab_ff  <= issue.in_table;
      end
   end

   // Packing state update
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_byte_ff <= '0;
         bits_filled_ff  <= '0;
         count_ff        <= '0;
      end else if (s1_adv) begin
         partial_byte_ff <= partial_byte_in;
         bits_filled_ff  <= bits_filled_in;
         count_ff        <= count_in;
      end
   end

   // Result register: load a group, drain one byte per handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_vld_ff <= 1'b0;
         grp_two_ff <= 1'b0;
      end else if (s1_adv && (n_out != 2'd0)) begin
         grp_vld_ff <= 1'b1;
         grp_two_ff <= (n_out == 2'd2);
      end else if (grp_vld_ff && rsp_ready) begin
         grp_vld_ff <= grp_two_ff;
         grp_two_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (n_out != 2'd0)) begin
         grp_b0_ff    <= byte0;
         grp_b1_ff    <= byte1;
         grp_total_ff <= count_in;
      end else if (grp_vld_ff && rsp_ready && grp_two_ff) begin
         grp_b0_ff <= grp_b1_ff;
      end
   end

   assign rsp_valid = grp_vld_ff;
   assign rsp_byte  = grp_b0_ff;
   assign rsp_last  = !grp_two_ff;
   assign rsp_total = grp_total_ff;

`ifndef SYNTHESIS
   a_partial_low_clear: assert property (@(posedge clock) disable iff (reset)
      (partial_byte_ff & (8'hFF >> bits_filled_ff)) == 8'h00)
      else $error("pending byte has bits below the fill point");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_adv) |-> grp_vld_ff)
      else $error("packing stage stalled with an empty result register");

   a_second_byte_follows: assert property (@(posedge clock) disable iff (reset)
      (grp_vld_ff && grp_two_ff && rsp_ready) |=> (grp_vld_ff && !grp_two_ff))
      else $error("second byte of an item lost or overwritten");

   a_count_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_kind_ff == hcbp_pkg::KIND_ENCODE) |-> (count_in >= count_ff))
      else $error("bit count wrapped");
`endif

endmodule

>>> rtl/core/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: stream ports, code table and packer.
`timescale 1ns / 1ps

// The block takes one item per cycle on the req_ channel while req_tready is high. A
// load item writes one entry of the 256-entry code table; an encode item reads its
// symbol's entry and appends the code, first bit into the top free bit of the
// pending byte; a flush item sends any pending bits as a zero padded byte. The first
// result of an item leaves on rsp_ after stage one and the result register. Each item
// yields zero, one or two bytes; the output register drains one byte per cycle while
// rsp_tready is high, so an item that completes two bytes holds the pipeline until
// its second byte drains, and the sustained rate is one item per cycle when items
// yield at most one byte and neither side stalls. After reset every table entry
// reads as a zero-length code until it is loaded; no clearing pass is needed.
module huffman_code_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // symbol[7:0], code_bits[23:8], code_len[28:24], zero
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_byte[7:0], bit_total[39:8]
   output logic        rsp_tlast    // last_of_run
);

   hcbp_pkg::issue_type                  issue;
   hcbp_pkg::entry_type                  rd_entry;
   logic [hcbp_pkg::SYM_W-1:0]           symbol;
   logic [hcbp_pkg::CODE_W-1:0]          code_bits;
   logic [hcbp_pkg::LEN_W-1:0]           code_len;
   logic [hcbp_pkg::BYTE_W-1:0]          out_byte;
   logic [hcbp_pkg::COUNT_W-1:0]         bit_total;
   logic                                 ready;

   // Unpack the request item
   assign symbol    = req_tdata[7:0];
   assign code_bits = req_tdata[23:8];
   assign code_len  = req_tdata[28:24];

   assign req_tready     = ready;
   assign issue.vld      = req_tvalid && ready;
   assign issue.kind     = req_tuser;
   assign issue.in_table = {1'b0, symbol} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::SYMBOL_COUNT);

   hcbp_table u_table (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .symbol    (symbol),
      .code_bits (code_bits),
      .code_len  (code_len),
      .rd_entry  (rd_entry)
   );

   hcbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rd_entry  (rd_entry),
      .ready     (ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (out_byte),
      .rsp_last  (rsp_tlast),
      .rsp_total (bit_total)
   );

   // Pack the result item
   assign rsp_tdata = {bit_total, out_byte};

endmodule

>>> dv/hcbp_byte_checker.sv
// Checker for the Huffman code bit packer: predicts packed bytes and compares results.
`timescale 1ns / 1ps

module hcbp_byte_checker
   import hcbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // symbol[7:0], code_bits[23:8], code_len[28:24], zero
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // out_byte[7:0], bit_total[39:8]
   input  logic        rsp_tlast,   // last_of_run
   output int          fail_count,
   output int          bytes_pending
);

   typedef struct {
      logic [BYTE_W-1:0]  out_byte;
      logic               last_of_run;
      logic [COUNT_W-1:0] bit_total;
   } packed_byte_type;

   // Predictor state: code table, byte under assembly, fill count, bit total
   entry_type          model_table [SYMBOL_COUNT];
   logic [BYTE_W-1:0]  model_partial;
   int unsigned        model_fill;
   logic [COUNT_W-1:0] model_count;
   packed_byte_type    byte_expect_q [$];

   // Work out the bytes one accepted item completes and queue them
   task automatic predict_item(input kind_type kind, input logic [SYM_W-1:0] sym,
                               input logic [CODE_W-1:0] code_in,
                               input logic [LEN_W-1:0] len_in);
      int unsigned       len;
      logic [CODE_W-1:0] code;
      logic [COUNT_W:0]  sum;
      logic              in_table;
      packed_byte_type   made [$];
      packed_byte_type   one;

      in_table = int'(sym) < SYMBOL_COUNT;
      case (kind)
         KIND_LOAD: begin
            if (in_table) begin
               len = len_in;
               if (len > LEN_CAP) len = LEN_CAP;
               code = code_in;
               // drop code bits above the stored length
               for (int i = len; i < CODE_W; i++) code[i] = 1'b0;
               model_table[sym].code = code;
               model_table[sym].len  = len[LEN_W-1:0];
            end
            return;
         end
         KIND_ENCODE: begin
            code = '0;
            len  = 0;
            if (in_table) begin
               code = model_table[sym].code;
               len  = model_table[sym].len;
            end
            if (len > CODE_W) len = CODE_W;
            // append the first code bit into the top free bit, emit each full byte
            for (int i = len; i > 0; i--) begin
               model_partial[7 - model_fill] = code[i-1];
               model_fill++;
               if (model_fill == BYTE_W) begin
                  one.out_byte = model_partial;
                  made = {made, one};
                  model_partial = '0;
                  model_fill    = 0;
               end
            end
            // saturate the running bit total
            sum = {1'b0, model_count} + len;
            model_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
         end
         KIND_FLUSH: begin
            if (model_fill != 0) begin
               one.out_byte = model_partial;
               made = {made, one};
               model_partial = '0;
               model_fill    = 0;
            end
         end
         default: return;
      endcase

      foreach (made[k]) begin
         made[k].last_of_run = (k == made.size() - 1);
         made[k].bit_total   = model_count;
         byte_expect_q = {byte_expect_q, made[k]};
      end
   endtask

   // Check results first, then predict the item accepted at this edge
   always @(posedge clock) begin
      packed_byte_type want;
      if (reset) begin
         foreach (model_table[s]) model_table[s] = '0;
         model_partial = '0;
         model_fill    = 0;
         model_count   = '0;
         byte_expect_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (byte_expect_q.size() == 0) begin
               $error("unexpected result item: out_byte %02h bit_total %0d",
                      rsp_tdata[7:0], rsp_tdata[39:8]);
               fail_count++;
            end else begin
               want = byte_expect_q.pop_front();
               if (rsp_tdata[7:0] !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last_of_run) begin
                  $error("last_of_run mismatch: expected %0b, actual %0b",
                         want.last_of_run, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tdata[39:8] !== want.bit_total) begin
                  $error("bit_total mismatch: expected %0d, actual %0d",
                         want.bit_total, rsp_tdata[39:8]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_item(kind_type'(req_tuser), req_tdata[7:0], req_tdata[23:8],
                         req_tdata[28:24]);
      end
      bytes_pending = byte_expect_q.size();
   end

endmodule

>>> dv/huffman_code_bit_packer_tb.sv
// Testbench top for the Huffman code bit packer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
   import hcbp_pkg::*;

   // Request kind the block ignores
   localparam kind_type KIND_UNUSED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        gaps_on    = 1'b1;
   int          fail_count;
   int          bytes_pending;

   huffman_code_bit_packer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   hcbp_byte_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending)
   );

   always #5 clock = ~clock;

   // Stall the result side now and then
   always @(negedge clock) begin
      rsp_tready = !(gaps_on && $urandom_range(99) < 8);
   end

   // Offer one item, with random idle cycles ahead of it, and hold until taken
   task automatic send_item(input kind_type kind, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 8) begin
         req_tvalid = 1'b0;
         req_tdata  = {3'b000, 29'($urandom)};
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {3'b000, len, code, sym};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random table entry: mostly low symbols so encodes hit loaded codes
   task automatic load_random_entry();
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] len;
      int               pick;
      sym  = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15));
      pick = $urandom_range(19);
      if (pick == 0)      len = 5'd0;
      else if (pick == 1) len = 5'($urandom_range(31, 17));
      else                len = 5'($urandom_range(16, 1));
      send_item(KIND_LOAD, sym, 16'($urandom_range(16'hFFFF)), len);
   endtask

   initial begin
      int pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table, nothing pending, ignored kind
      send_item(KIND_ENCODE, 8'd0, 16'hFFFF, 5'd16);
      send_item(KIND_FLUSH, 8'd0, 16'h0000, 5'd0);
      send_item(KIND_UNUSED, 8'd255, 16'hFFFF, 5'd31);
      // Loads: full width, one bit, overlong length, masked code, all zero code
      send_item(KIND_LOAD, 8'd255, 16'hFFFF, 5'd16);
      send_item(KIND_LOAD, 8'd0, 16'hFFFF, 5'd1);
      send_item(KIND_LOAD, 8'd1, 16'hFFFF, 5'd31);
      send_item(KIND_LOAD, 8'd2, 16'hFFFF, 5'd3);
      send_item(KIND_LOAD, 8'd3, 16'h0000, 5'd16);
      send_item(KIND_LOAD, 8'd128, 16'hA5C3, 5'd9);
      // Encodes that complete zero, one and two bytes
      send_item(KIND_ENCODE, 8'd0, 16'h0000, 5'd0);
      send_item(KIND_ENCODE, 8'd255, 16'h0000, 5'd0);
      send_item(KIND_ENCODE, 8'd1, 16'h0000, 5'd0);
      send_item(KIND_ENCODE, 8'd2, 16'h0000, 5'd0);
      send_item(KIND_FLUSH, 8'd0, 16'h0000, 5'd0);
      send_item(KIND_ENCODE, 8'd3, 16'h0000, 5'd0);
      send_item(KIND_ENCODE, 8'd128, 16'h0000, 5'd0);
      send_item(KIND_FLUSH, 8'd255, 16'hFFFF, 5'd31);
      // Zero-length entry, then an exact byte from an empty fill
      send_item(KIND_LOAD, 8'd4, 16'hFFFF, 5'd0);
      send_item(KIND_ENCODE, 8'd4, 16'h0000, 5'd0);
      send_item(KIND_LOAD, 8'd5, 16'h5555, 5'd8);
      send_item(KIND_ENCODE, 8'd5, 16'h0000, 5'd0);
      send_item(KIND_ENCODE, 8'd77, 16'h0000, 5'd0);

      // Random mix; a middle stretch runs without idle cycles on either side
      for (int n = 0; n < 330; n++) begin
         gaps_on = !(n >= 120 && n < 200);
         pick = $urandom_range(99);
         if (pick < 25)
            load_random_entry();
         else if (pick < 85)
            send_item(KIND_ENCODE,
                      8'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                  : $urandom_range(15)),
                      16'($urandom_range(16'hFFFF)), 5'($urandom_range(31)));
         else if (pick < 97)
            send_item(KIND_FLUSH, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                      5'($urandom_range(31)));
         else
            send_item(KIND_UNUSED, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                      5'($urandom_range(31)));
      end

      // Drain, then keep the clock running so that stray results show
      @(negedge clock);
      req_tvalid = 1'b0;
      gaps_on    = 1'b1;
      wait (bytes_pending == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Stop a hung run
   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

endmodule
